/* hw/rtl/bcm_pkg.sv */
// Shared types and constants for the binomial-mod-prime table block.
package bcm_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int AddrW      = $clog2(TABLE_SIZE);
  localparam int MulLat     = 6;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  localparam logic [29:0] PRIME   = 30'd1000000007;
  localparam logic [31:0] PRIME32 = 32'd1000000007;
  localparam logic [31:0] TWO_P   = 32'd2000000014;
  // exponent for the Fermat inverse: p - 2
  localparam logic [29:0] INV_EXP = 30'd1000000005;

  // Barrett constant floor(2^60 / p)
  localparam logic [63:0] BarNum = 64'd1 << 60;
  localparam logic [30:0] BAR_M  = 31'(BarNum / 64'd1000000007);

  typedef logic [29:0]      residue_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef struct packed {
    logic  ok;
    logic  oor;
  } flags_t;

  typedef struct packed {
    flags_t flags;
    addr_t  n;
    addr_t  k;
    addr_t  d;
  } query_t;

  typedef struct packed {
    logic     fac_we;
    logic     finv_we;
    addr_t    addr;
    residue_t data;
  } tbl_wr_t;

endpackage

/* hw/rtl/bcm_modmul.sv */
// Pipelined modular multiplier, Barrett reduction by the fixed prime.
module bcm_modmul (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  bcm_pkg::residue_t a,
  input  bcm_pkg::residue_t b,
  output logic             out_valid,
  output bcm_pkg::residue_t r
);
  import bcm_pkg::*;

  logic [5:0]  v;
  logic [59:0] p1;
  logic [60:0] mh, ml;
  logic [31:0] x2, x3, x4;
  logic [30:0] q3;
  logic [31:0] qp4;
  logic [31:0] r5;
  logic [29:0] r6;
  logic [90:0] qsum;
  logic [60:0] qp_full;

  assign qsum    = {mh, 30'b0} + {30'b0, ml};
  assign qp_full = q3 * PRIME;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= a * b;
      mh  <= p1[59:30] * BAR_M;
      ml  <= p1[29:0] * BAR_M;
      x2  <= p1[31:0];
      q3  <= qsum[90:60];
      x3  <= x2;
      qp4 <= qp_full[31:0];
      x4  <= x3;
      // true remainder is below 3p, so 32 bits of the difference suffice
      r5  <= x4 - qp4;
      if (r5 >= TWO_P) begin
        r6 <= 30'(r5 - TWO_P);
      end else if (r5 >= PRIME32) begin
        r6 <= 30'(r5 - PRIME32);
      end else begin
        r6 <= r5[29:0];
      end
    end
  end

  assign out_valid = v[5];
  assign r         = r6;

endmodule

/* hw/rtl/bcm_builder.sv */
// Table build sequencer: factorials forward, Fermat inverse, inverse factorials backward.
module bcm_builder (
  input  logic             clk,
  input  logic             rst,
  output bcm_pkg::tbl_wr_t wr,
  output logic             ready
);
  import bcm_pkg::*;

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_FAC  = 5'b00010,
    ST_POW  = 5'b00100,
    ST_BACK = 5'b01000,
    ST_DONE = 5'b10000
  } bstate_t;

  localparam addr_t LastIdx = AddrW'(TABLE_SIZE - 1);
  localparam addr_t TwoIdx  = AddrW'(2);

  bstate_t  state;
  logic     busy;
  addr_t    idx;
  residue_t acc;
  residue_t base;
  logic [4:0] bitpos;
  logic     pow_sq;

  logic     mul_in_valid;
  residue_t mul_b;
  logic     mul_out_valid;
  residue_t mul_r;

  always_comb begin
    mul_in_valid = !busy && (state == ST_FAC || state == ST_POW || state == ST_BACK);
    if (state == ST_POW) begin
      mul_b = pow_sq ? acc : base;
    end else begin
      mul_b = 30'(idx);
    end
  end

  bcm_modmul u_mul (
    .clk      (clk),
    .rst      (rst),
    .en       (1'b1),
    .in_valid (mul_in_valid),
    .a        (acc),
    .b        (mul_b),
    .out_valid(mul_out_valid),
    .r        (mul_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      busy       <= 1'b0;
      wr.fac_we  <= 1'b0;
      wr.finv_we <= 1'b0;
    end else begin
      wr.fac_we  <= 1'b0;
      wr.finv_we <= 1'b0;
      if (mul_in_valid) begin
        busy <= 1'b1;
      end
      if (mul_out_valid) begin
        busy <= 1'b0;
        acc  <= mul_r;
      end
      unique case (state)
        ST_INIT: begin
          wr.fac_we  <= 1'b1;
          wr.finv_we <= 1'b1;
          wr.addr    <= '0;
          wr.data    <= 30'd1;
          acc        <= 30'd1;
          idx        <= AddrW'(1);
          state      <= ST_FAC;
        end
        ST_FAC: begin
          if (mul_out_valid) begin
            wr.fac_we <= 1'b1;
            wr.addr   <= idx;
            wr.data   <= mul_r;
            if (idx == LastIdx) begin
              base   <= mul_r;
              acc    <= 30'd1;
              bitpos <= 5'd29;
              pow_sq <= 1'b1;
              state  <= ST_POW;
            end else begin
              idx <= idx + AddrW'(1);
            end
          end
        end
        ST_POW: begin
          if (mul_out_valid) begin
            if (pow_sq && INV_EXP[bitpos]) begin
              pow_sq <= 1'b0;
            end else if (bitpos == 5'd0) begin
              wr.finv_we <= 1'b1;
              wr.addr    <= LastIdx;
              wr.data    <= mul_r;
              idx        <= LastIdx;
              state      <= (TABLE_SIZE == 2) ? ST_DONE : ST_BACK;
            end else begin
              pow_sq <= 1'b1;
              bitpos <= bitpos - 5'd1;
            end
          end
        end
        ST_BACK: begin
          // finv[i-1] = finv[i] * i
          if (mul_out_valid) begin
            wr.finv_we <= 1'b1;
            wr.addr    <= idx - AddrW'(1);
            wr.data    <= mul_r;
            if (idx == TwoIdx) begin
              state <= ST_DONE;
            end else begin
              idx <= idx - AddrW'(1);
            end
          end
        end
        ST_DONE: begin
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

  assign ready = (state == ST_DONE);

endmodule

/* hw/rtl/bcm_front.sv */
// Query front end: input handshake and argument classification.
module bcm_front (
  input  logic            ready,
  input  logic            full,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [39:0]     s_axis_tdata,
  output logic            push,
  output bcm_pkg::query_t q
);
  import bcm_pkg::*;

  localparam logic signed [19:0] NLimit = 20'(TABLE_SIZE);

  logic signed [19:0] n, k;
  logic [19:0] diff;

  assign n    = s_axis_tdata[19:0];
  assign k    = s_axis_tdata[39:20];
  assign diff = n - k;

  always_comb begin
    q.flags.oor = (n >= NLimit);
    q.flags.ok  = !q.flags.oor && !n[19] && !k[19] && (n >= k);
    q.n         = n[AddrW-1:0];
    q.k         = k[AddrW-1:0];
    q.d         = diff[AddrW-1:0];
  end

  assign s_axis_tready = ready && !full;
  assign push          = s_axis_tvalid && s_axis_tready;

endmodule

/* hw/rtl/bcm_queue.sv */
// Short queue of classified queries between front and back.
module bcm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bcm_pkg::query_t din,
  output logic            full,
  input  logic            pop,
  output bcm_pkg::query_t dout,
  output logic            empty
);
  import bcm_pkg::*;

  query_t           slots [QueueDepth];
  logic [QPtrW-1:0] wptr, rptr;
  logic [QPtrW:0]   count;

  assign full  = (count == (QPtrW+1)'(QueueDepth));
  assign empty = (count == '0);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPtrW'(1);
      end
      if (pop) begin
        rptr <= rptr + QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + (QPtrW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPtrW+1)'(1);
      end
    end
  end

endmodule

/* hw/rtl/bcm_back.sv */
// Query back end: table memories, two chained modular multiplies, output stage.
module bcm_back (
  input  logic             clk,
  input  logic             rst,
  input  bcm_pkg::tbl_wr_t wr,
  input  logic             empty,
  input  bcm_pkg::query_t  head,
  output logic             pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tuser
);
  import bcm_pkg::*;

  residue_t fac_mem  [TABLE_SIZE];
  residue_t finv_mem [TABLE_SIZE];

  logic     ce;
  logic     v0;
  flags_t   flags0;
  residue_t fac_rd, finvk_rd, finvd_rd;
  residue_t dline [MulLat];
  flags_t   fline [2*MulLat];
  logic     v1;
  residue_t r1, r2;
  logic     out_valid;

  // whole pipeline holds while the result in the last stage is not taken
  assign ce  = !out_valid || m_axis_tready;
  assign pop = ce && !empty;

  always_ff @(posedge clk) begin
    if (wr.fac_we) begin
      fac_mem[wr.addr] <= wr.data;
    end
    if (ce) begin
      fac_rd <= fac_mem[head.n];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.finv_we) begin
      finv_mem[wr.addr] <= wr.data;
    end
    if (ce) begin
      finvk_rd <= finv_mem[head.k];
      finvd_rd <= finv_mem[head.d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ce) begin
      v0 <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      flags0   <= head.flags;
      dline[0] <= finvd_rd;
      fline[0] <= flags0;
      for (int i = 1; i < MulLat; i++) begin
        dline[i] <= dline[i-1];
      end
      for (int i = 1; i < 2*MulLat; i++) begin
        fline[i] <= fline[i-1];
      end
    end
  end

  bcm_modmul u_mul1 (
    .clk      (clk),
    .rst      (rst),
    .en       (ce),
    .in_valid (v0),
    .a        (fac_rd),
    .b        (finvk_rd),
    .out_valid(v1),
    .r        (r1)
  );

  bcm_modmul u_mul2 (
    .clk      (clk),
    .rst      (rst),
    .en       (ce),
    .in_valid (v1),
    .a        (r1),
    .b        (dline[MulLat-1]),
    .out_valid(out_valid),
    .r        (r2)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, fline[2*MulLat-1].ok ? r2 : 30'd0};
  assign m_axis_tuser  = fline[2*MulLat-1].oor;

endmodule

/* hw/rtl/binomial_mod_prime_table_top.sv */
// Binomial coefficient mod 1000000007 from built factorial tables.
// After reset the tables are built (one shared six-stage modular multiplier, one product
// in flight); s_axis_tready stays low until done.
// Then one query is taken per cycle while the queue is not full; each result passes
// through the queue, a registered table read and two six-stage modular multipliers.
// rst is synchronous, active high, and restarts the build.
module binomial_mod_prime_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [19:0] top_count, [39:20] choose_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [29:0] coefficient, [31:30] zero
  output logic        m_axis_tuser    // [0] out_of_range
);
  import bcm_pkg::*;

  tbl_wr_t wr;
  logic    tables_ready;
  logic    push, pop, full, empty;
  query_t  q_in, q_head;

  bcm_builder u_builder (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .ready(tables_ready)
  );

  bcm_front u_front (
    .ready        (tables_ready),
    .full         (full),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .push         (push),
    .q            (q_in)
  );

  bcm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (q_in),
    .full (full),
    .pop  (pop),
    .dout (q_head),
    .empty(empty)
  );

  bcm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .empty        (empty),
    .head         (q_head),
    .pop          (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  a_no_query_before_build: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> tables_ready)
    else $error("query taken before tables built");

  a_no_result_before_build: assert property (@(posedge clk) disable iff (rst)
    !tables_ready |-> !m_axis_tvalid)
    else $error("result shown before tables built");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[29:0] == 30'd0)
    else $error("out-of-range result carries a nonzero coefficient");

  // the last inverse-factorial write lands in the first ready cycle
  a_no_table_write_after_build: assert property (@(posedge clk) disable iff (rst)
    tables_ready && $past(tables_ready) |-> !wr.fac_we && !wr.finv_we)
    else $error("table written after build");

endmodule

/* bench/binomial_mod_prime_table_checker.sv */
// Checker for the binomial table block: watches both streams, predicts and compares.
module binomial_mod_prime_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          errors,
  output int          pending,
  output int          queries_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import bcm_pkg::*;

  typedef struct packed {
    logic [29:0] coef;
    logic        oor;
  } answer_t;

  localparam longint unsigned P = 64'd1000000007;

  logic [29:0] fac_tbl [TABLE_SIZE];
  logic [29:0] inv_tbl [TABLE_SIZE];
  logic [29:0] finv_tbl [TABLE_SIZE];
  answer_t answers_due [$];

  function automatic logic [29:0] mulmod(logic [29:0] a, logic [29:0] b);
    longint unsigned prod;
    prod = longint'(a) * longint'(b);
    return 30'(prod % P);
  endfunction

  // tables built differently from the hardware: modular-inverse recurrence, then running products
  initial begin
    longint unsigned t;
    fac_tbl[0] = 30'd1; fac_tbl[1] = 30'd1;
    finv_tbl[0] = 30'd1; finv_tbl[1] = 30'd1;
    inv_tbl[0] = 30'd0; inv_tbl[1] = 30'd1;
    for (int i = 2; i < TABLE_SIZE; i++) begin
      t = longint'(mulmod(inv_tbl[P % i], 30'(P / i)));
      inv_tbl[i] = (t == 0) ? 30'd0 : 30'(P - t);
      fac_tbl[i] = mulmod(fac_tbl[i-1], 30'(i));
      finv_tbl[i] = mulmod(finv_tbl[i-1], inv_tbl[i]);
    end
  end

  function automatic answer_t binomial(logic signed [19:0] n, logic signed [19:0] k);
    answer_t a;
    a.oor = (n >= TABLE_SIZE);
    a.coef = '0;
    if (!a.oor && n >= k && n >= 0 && k >= 0)
      a.coef = mulmod(mulmod(fac_tbl[n], finv_tbl[k]), finv_tbl[n - k]);
    return a;
  endfunction

  assign pending = answers_due.size();

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      answers_due.delete();
      errors <= 0;
      queries_seen <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        answers_due.push_back(binomial(s_axis_tdata[19:0], s_axis_tdata[39:20]));
        queries_seen <= queries_seen + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers_due.size() == 0) begin
          if (errors < 10) $display("unexpected result %h/%b", m_axis_tdata, m_axis_tuser);
          errors <= errors + 1;
        end else begin
          want = answers_due.pop_front();
          if (m_axis_tdata !== {2'b00, want.coef} || m_axis_tuser !== want.oor) begin
            if (errors < 10)
              $display("mismatch: expected coef %0d oor %b, got data %h oor %b",
                       want.coef, want.oor, m_axis_tdata, m_axis_tuser);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

/* bench/binomial_mod_prime_table_top_test.sv */
// Top of the binomial table testbench: clock, reset, stimulus and verdict.
module binomial_mod_prime_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bcm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          errors, pending, queries_seen;
  int          cycles = 0;
  bit          hold_sink = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  binomial_mod_prime_table_top DUT (.*);

  binomial_mod_prime_table_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout");
      $display("binomial_mod_prime_table_top_test NOT OK");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // result side: random stalls, plus one long hold-off
  initial begin
    int g;
    repeat (5) @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_sink = 0;
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      if (queries_seen > 900 && queries_seen < 1300) g = 0;
      else g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic send(int n, int k);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {20'(k), 20'(n)};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic rest();
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    int n, k, mode;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed: edges, zero cases, out of range
    send(0, 0); send(1, 0); send(1, 1); send(5, 2); send(10, 5);
    send(TABLE_SIZE - 1, 0); send(TABLE_SIZE - 1, TABLE_SIZE - 1);
    send(TABLE_SIZE - 1, 2047); send(TABLE_SIZE - 1, 1234);
    send(TABLE_SIZE, 3); send(TABLE_SIZE, -1); send(524287, 524287);
    send(-524288, -524288); send(-1, 0); send(3, -1); send(3, 4);
    send(0, 524287); send(-524288, 524287); send(2, 1);
    send(20'h55555, 20'h2AAAA); send(20'h2AAAA, 20'h55555);
    s_axis_tvalid <= 1'b0;
    // sender pause until drained
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    for (int i = 0; i < 1830; i++) begin
      if (i == 400) hold_sink = 1;
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        n = $urandom_range(0, TABLE_SIZE - 1);
        k = $urandom_range(0, n);
      end else if (mode == 7) begin
        n = $urandom_range(0, TABLE_SIZE - 1);
        k = $urandom_range(0, 2 * TABLE_SIZE);
      end else begin
        n = $urandom; k = $urandom;
      end
      send(n, k);
      if (i < 400 || i > 450) rest();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("covered %0d queries: edges of n and k, negatives, n<k, out of range,",
             queries_seen);
    $display("random in-table and wide arguments under source and sink stalls");
    if (errors == 0 && pending == 0) begin
      $display("binomial_mod_prime_table_top_test OK");
    end else begin
      $display("binomial_mod_prime_table_top_test NOT OK");
    end
    $finish;
  end
endmodule
